>>> sv/arxp_pkg.sv
// ----------------------------------------------------------------------------
// ARX permutation package
// Shared types, command and operation codes, and the round functions of the
// keyless add-rotate-xor permutation.
// ----------------------------------------------------------------------------
`default_nettype none

package arxp_pkg;

    // Default largest number of full rounds for one item.
    localparam int MAX_ROUNDS_DEF = 16;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int WORD_W = 32;
    localparam int CMD_W  = 3;
    localparam int RCNT_W = 5;
    localparam int OP_W   = 3;

    // Command codes as they arrive on the input channel.
    localparam logic [CMD_W-1:0] CMD_FWD_ROUNDS = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INV_ROUNDS = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FWD_HALF_A = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FWD_HALF_B = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INV_HALF_B = 3'd4;

    // Operation codes that the round unit applies once per step.
    localparam logic [OP_W-1:0] OP_PASS      = 3'd0;
    localparam logic [OP_W-1:0] OP_FWD_ROUND = 3'd1;
    localparam logic [OP_W-1:0] OP_INV_ROUND = 3'd2;
    localparam logic [OP_W-1:0] OP_FWD_A     = 3'd3;
    localparam logic [OP_W-1:0] OP_FWD_B     = 3'd4;
    localparam logic [OP_W-1:0] OP_INV_B     = 3'd5;

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word [3:0]       t_state;

    // One classified job: the operation and the state it works on.
    typedef struct packed {
        logic [OP_W-1:0] op;
        t_state          s;
    } t_job;

    function automatic t_word rotl(input t_word x, input int b);
        return (x << b) | (x >> (WORD_W - b));
    endfunction

    function automatic t_word rotr(input t_word x, input int b);
        return (x >> b) | (x << (WORD_W - b));
    endfunction

    // First forward half round.
    function automatic t_state half_fwd_a(input t_state s);
        t_state t;
        t    = s;
        t[0] = s[0] + s[1];
        t[1] = rotl(s[1], 5) ^ t[0];
        t[0] = rotl(t[0], 16);
        t[2] = s[2] + s[3];
        t[3] = rotl(s[3], 8) ^ t[2];
        return t;
    endfunction

    // Second forward half round.
    function automatic t_state half_fwd_b(input t_state s);
        t_state t;
        t    = s;
        t[0] = s[0] + s[3];
        t[3] = rotl(s[3], 13) ^ t[0];
        t[2] = s[2] + s[1];
        t[1] = rotl(s[1], 7) ^ t[2];
        t[2] = rotl(t[2], 16);
        return t;
    endfunction

    // Inverse of the second half round.
    function automatic t_state half_inv_b(input t_state s);
        t_state t;
        t    = s;
        t[2] = rotr(s[2], 16);
        t[1] = rotr(s[1] ^ t[2], 7);
        t[2] = t[2] - t[1];
        t[3] = rotr(s[3] ^ s[0], 13);
        t[0] = s[0] - t[3];
        return t;
    endfunction

    // Inverse of the first half round.
    function automatic t_state half_inv_a(input t_state s);
        t_state t;
        t    = s;
        t[3] = rotr(s[3] ^ s[2], 8);
        t[2] = s[2] - t[3];
        t[0] = rotr(s[0], 16);
        t[1] = rotr(s[1] ^ t[0], 5);
        t[0] = t[0] - t[1];
        return t;
    endfunction

    // One step of the round unit for a given operation.
    function automatic t_state round_step(input logic [OP_W-1:0] op, input t_state s);
        t_state t;
        case (op)
            OP_FWD_ROUND: t = half_fwd_b(half_fwd_a(s));
            OP_INV_ROUND: t = half_inv_a(half_inv_b(s));
            OP_FWD_A:     t = half_fwd_a(s);
            OP_FWD_B:     t = half_fwd_b(s);
            OP_INV_B:     t = half_inv_b(s);
            default:      t = s;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

>>> sv/arxp_if.sv
// ----------------------------------------------------------------------------
// ARX permutation channel interfaces
// Valid/ready channels for the input items and the permuted results.
// ----------------------------------------------------------------------------
`default_nettype none

interface arxp_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [4:0]  round_count;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;

    modport source (output valid, command, round_count, word0, word1, word2, word3,
                    input ready);
    modport sink   (input valid, command, round_count, word0, word1, word2, word3,
                    output ready);
endinterface

interface arxp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_word0;
    logic [31:0] out_word1;
    logic [31:0] out_word2;
    logic [31:0] out_word3;

    modport source (output valid, out_word0, out_word1, out_word2, out_word3,
                    input ready);
    modport sink   (input valid, out_word0, out_word1, out_word2, out_word3,
                    output ready);
endinterface

`default_nettype wire

>>> sv/arxp_front.sv
// ----------------------------------------------------------------------------
// ARX permutation front end
// Accepts input items, decodes the command into a round-unit operation and a
// step count (saturated to the round limit), and pushes the job to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module arxp_front #(
    parameter int MAX_ROUNDS = arxp_pkg::MAX_ROUNDS_DEF,
    parameter int CNT_W      = $clog2(MAX_ROUNDS + 1)
) (
    arxp_in_if.sink              i_in,
    output logic                 o_push_valid,
    input  logic                 i_push_ready,
    output arxp_pkg::t_job       o_job,
    output logic [CNT_W-1:0]     o_cnt
);
    import arxp_pkg::*;

    logic [CNT_W-1:0] sat_rounds;

    // A transfer on the input moves straight into the queue.
    assign i_in.ready   = i_push_ready;
    assign o_push_valid = i_in.valid;

    // Round count limited to the largest supported count.
    always_comb begin
        if (int'(i_in.round_count) > MAX_ROUNDS) begin
            sat_rounds = CNT_W'(MAX_ROUNDS);
        end else begin
            sat_rounds = CNT_W'(i_in.round_count);
        end
    end

    // Command decode; unused codes pass the state through.
    always_comb begin
        o_job.s = {i_in.word3, i_in.word2, i_in.word1, i_in.word0};
        case (i_in.command)
            CMD_FWD_ROUNDS: begin
                o_job.op = OP_FWD_ROUND;
                o_cnt    = sat_rounds;
            end
            CMD_INV_ROUNDS: begin
                o_job.op = OP_INV_ROUND;
                o_cnt    = sat_rounds;
            end
            CMD_FWD_HALF_A: begin
                o_job.op = OP_FWD_A;
                o_cnt    = CNT_W'(1);
            end
            CMD_FWD_HALF_B: begin
                o_job.op = OP_FWD_B;
                o_cnt    = CNT_W'(1);
            end
            CMD_INV_HALF_B: begin
                o_job.op = OP_INV_B;
                o_cnt    = CNT_W'(1);
            end
            default: begin
                o_job.op = OP_PASS;
                o_cnt    = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/arxp_queue.sv
// ----------------------------------------------------------------------------
// ARX permutation job queue
// Short register FIFO that decouples the front end from the round unit.
// ----------------------------------------------------------------------------
`default_nettype none

module arxp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = arxp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and fill count update with wrap at the depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> sv/arxp_back.sv
// ----------------------------------------------------------------------------
// ARX permutation round unit
// Takes jobs from the queue, applies one round-unit step per cycle until the
// step count runs out, and hands the state to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module arxp_back #(
    parameter int CNT_W = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    input  arxp_pkg::t_job       i_job,
    input  logic [CNT_W-1:0]     i_cnt,
    output logic                 o_pop,
    arxp_out_if.source           o_out
);
    import arxp_pkg::*;

    logic             r_busy,      n_busy;
    logic [CNT_W-1:0] r_cnt,       n_cnt;
    logic [OP_W-1:0]  r_op,        n_op;
    t_state           r_s,         n_s;
    logic             r_out_valid, n_out_valid;
    t_state           r_out,       n_out;
    logic             out_free;

    // The output register is free when empty or when its transfer happens now.
    assign out_free = !r_out_valid || o_out.ready;
    assign o_pop    = i_job_valid && !r_busy;

    always_comb begin
        n_busy      = r_busy;
        n_cnt       = r_cnt;
        n_op        = r_op;
        n_s         = r_s;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out       = r_out;
        if (!r_busy) begin
            // Load the next job from the queue.
            if (i_job_valid) begin
                n_busy = 1'b1;
                n_cnt  = i_cnt;
                n_op   = i_job.op;
                n_s    = i_job.s;
            end
        end else if (r_cnt != '0) begin
            // One step of the shared round unit.
            n_s   = round_step(r_op, r_s);
            n_cnt = r_cnt - CNT_W'(1);
        end else if (out_free) begin
            // Work done: move the state into the output register.
            n_busy      = 1'b0;
            n_out_valid = 1'b1;
            n_out       = r_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    // Working state and result payload.
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_op  <= n_op;
        r_s   <= n_s;
        r_out <= n_out;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_word0 = r_out[0];
    assign o_out.out_word1 = r_out[1];
    assign o_out.out_word2 = r_out[2];
    assign o_out.out_word3 = r_out[3];

endmodule

`default_nettype wire

>>> sv/arx_permutation_rounds.sv
// ----------------------------------------------------------------------------
// ARX permutation rounds
// Keyless add-rotate-xor permutation of a 128-bit state: full forward or
// inverse rounds, or single half rounds, selected per item by a command.
//
//   Port    Dir  Handshake    Carries
//   i_in    in   valid/ready  command, round_count, word0..word3
//   o_out   out  valid/ready  out_word0..out_word3
//
// The number of round-unit steps for an item is the saturated round count
// for full-round commands, one for a half round, zero for unused commands.
// The single shared round unit does one step, a full round or a half round,
// per cycle and works on one job at a time, taking the next job only once
// the last result has moved into the output register. A two-entry queue
// keeps taking items while the unit is busy, and the output register holds
// a result under back-pressure. Reset is synchronous, active low, and
// clears only control state.
// ----------------------------------------------------------------------------
`default_nettype none

module arx_permutation_rounds #(
    parameter int MAX_ROUNDS  = arxp_pkg::MAX_ROUNDS_DEF,
    parameter int QUEUE_DEPTH = arxp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    arxp_in_if.sink    i_in,
    arxp_out_if.source o_out
);
    import arxp_pkg::*;

    localparam int CNT_W = $clog2(MAX_ROUNDS + 1);
    localparam int QW    = $bits(t_job) + CNT_W;

    logic             push_valid;
    logic             q_full;
    t_job             front_job;
    logic [CNT_W-1:0] front_cnt;
    logic             q_valid;
    logic             q_pop;
    logic [QW-1:0]    q_data;
    t_job             back_job;
    logic [CNT_W-1:0] back_cnt;

    // Command decode and input transfer.
    arxp_front #(
        .MAX_ROUNDS (MAX_ROUNDS),
        .CNT_W      (CNT_W)
    ) u_front (
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .i_push_ready (!q_full),
        .o_job        (front_job),
        .o_cnt        (front_cnt)
    );

    // Job queue between decode and the round unit.
    arxp_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_valid),
        .i_data  ({front_cnt, front_job}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign back_cnt = q_data[QW-1 -: CNT_W];
    assign back_job = q_data[$bits(t_job)-1:0];

    // Shared round unit and result register.
    arxp_back #(
        .CNT_W (CNT_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (back_job),
        .i_cnt       (back_cnt),
        .o_pop       (q_pop),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ARX permutation rounds testbench
// Drives permutation jobs over the input channel, predicts each permuted
// state in the testbench, and compares every output transfer word by word
// in order. A short table of directed jobs comes first, then random jobs
// with random idling on both channels. There is also one long output
// hold-off that backs the block up, and one pause that drains it.
// ----------------------------------------------------------------------------

module testbench;

    import arxp_pkg::*;

    typedef logic [WORD_W-1:0] t_perm_word;
    typedef t_perm_word [3:0]  t_perm_state;

    // Commands the block does not define. They must pass the state through.
    localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam int ROUND_LIMIT   = MAX_ROUNDS_DEF;
    localparam int RANDOM_JOBS   = 600;
    localparam int HOLD_CYCLES   = 80;
    localparam int STALL_LIMIT   = 2000;
    localparam int DIRECTED_ROWS = 22;

    localparam t_perm_state ALL_ZERO = '0;
    localparam t_perm_state ALL_ONES = '1;
    localparam t_perm_state CHECKER  = {32'h5A5A_A5A5, 32'hA5A5_5A5A,
                                        32'h0F0F_F0F0, 32'hF0F0_0F0F};
    localparam t_perm_state COUNTING = {32'h0C0D_0E0F, 32'h0809_0A0B,
                                        32'h0405_0607, 32'h0001_0203};
    localparam t_perm_state EDGE_BITS = {4{32'h8000_0001}};

    // One directed job. When known is set, result holds the expected state.
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [RCNT_W-1:0] rcnt;
        t_perm_state       state;
        bit                known;
        t_perm_state       result;
    } t_job_row;

    t_job_row directed_jobs [DIRECTED_ROWS] = '{
        // An all-zero state stays zero under every operation.
        '{CMD_FWD_ROUNDS, 5'd1,  ALL_ZERO,  1'b1, ALL_ZERO},
        '{CMD_INV_ROUNDS, 5'd1,  ALL_ZERO,  1'b1, ALL_ZERO},
        '{CMD_FWD_HALF_A, 5'd0,  ALL_ZERO,  1'b1, ALL_ZERO},
        '{CMD_FWD_HALF_B, 5'd31, ALL_ZERO,  1'b1, ALL_ZERO},
        '{CMD_INV_HALF_B, 5'd16, ALL_ZERO,  1'b1, ALL_ZERO},
        // A zero round count and the spare commands pass the state through.
        '{CMD_FWD_ROUNDS, 5'd0,  ALL_ONES,  1'b1, ALL_ONES},
        '{CMD_INV_ROUNDS, 5'd0,  CHECKER,   1'b1, CHECKER},
        '{CMD_SPARE_5,    5'd8,  CHECKER,   1'b1, CHECKER},
        '{CMD_SPARE_6,    5'd31, COUNTING,  1'b1, COUNTING},
        '{CMD_SPARE_7,    5'd0,  ALL_ONES,  1'b1, ALL_ONES},
        // Full rounds below the limit, at it and beyond it, where the count saturates.
        '{CMD_FWD_ROUNDS, 5'd16, ALL_ONES,  1'b0, ALL_ZERO},
        '{CMD_INV_ROUNDS, 5'd16, ALL_ONES,  1'b0, ALL_ZERO},
        '{CMD_FWD_ROUNDS, 5'd31, CHECKER,   1'b0, ALL_ZERO},
        '{CMD_INV_ROUNDS, 5'd17, CHECKER,   1'b0, ALL_ZERO},
        '{CMD_FWD_ROUNDS, 5'd8,  COUNTING,  1'b0, ALL_ZERO},
        '{CMD_INV_ROUNDS, 5'd8,  COUNTING,  1'b0, ALL_ZERO},
        // Single half rounds, where the round count is ignored, and single full rounds.
        '{CMD_FWD_HALF_A, 5'd1,  ALL_ONES,  1'b0, ALL_ZERO},
        '{CMD_FWD_HALF_B, 5'd1,  EDGE_BITS, 1'b0, ALL_ZERO},
        '{CMD_INV_HALF_B, 5'd1,  ALL_ONES,  1'b0, ALL_ZERO},
        '{CMD_FWD_HALF_A, 5'd31, COUNTING,  1'b0, ALL_ZERO},
        '{CMD_FWD_ROUNDS, 5'd1,  EDGE_BITS, 1'b0, ALL_ZERO},
        '{CMD_INV_ROUNDS, 5'd1,  EDGE_BITS, 1'b0, ALL_ZERO}
    };

    logic i_clk;
    logic i_rst_n;

    arxp_in_if  in_ch ();
    arxp_out_if out_ch ();

    arx_permutation_rounds u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_perm_state pending_states [$];
    int          mismatches;
    bit          calm;
    bit          hold_request;
    int          idle_cycles;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Permutation predictor
    // ------------------------------------------------------------------

    function automatic t_perm_word rol(input t_perm_word x, input int unsigned n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

    function automatic t_perm_word ror(input t_perm_word x, input int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic t_perm_state mix_first_half(input t_perm_state s);
        t_perm_word a, b, c, d;
        a = s[0]; b = s[1]; c = s[2]; d = s[3];
        a = a + b;  b = rol(b, 5) ^ a;  a = rol(a, 16);
        c = c + d;  d = rol(d, 8) ^ c;
        return {d, c, b, a};
    endfunction

    function automatic t_perm_state mix_second_half(input t_perm_state s);
        t_perm_word a, b, c, d;
        a = s[0]; b = s[1]; c = s[2]; d = s[3];
        a = a + d;  d = rol(d, 13) ^ a;
        c = c + b;  b = rol(b, 7) ^ c;  c = rol(c, 16);
        return {d, c, b, a};
    endfunction

    function automatic t_perm_state unmix_second_half(input t_perm_state s);
        t_perm_word a, b, c, d;
        a = s[0]; b = s[1]; c = s[2]; d = s[3];
        c = ror(c, 16);  b = ror(b ^ c, 7);  c = c - b;
        d = ror(d ^ a, 13);  a = a - d;
        return {d, c, b, a};
    endfunction

    function automatic t_perm_state unmix_first_half(input t_perm_state s);
        t_perm_word a, b, c, d;
        a = s[0]; b = s[1]; c = s[2]; d = s[3];
        d = ror(d ^ c, 8);  c = c - d;
        a = ror(a, 16);  b = ror(b ^ a, 5);  a = a - b;
        return {d, c, b, a};
    endfunction

    // Expected output state for one job.
    function automatic t_perm_state permute_state(input logic [CMD_W-1:0] cmd,
                                                  input logic [RCNT_W-1:0] rcnt,
                                                  input t_perm_state s);
        int unsigned n;
        t_perm_state t;
        n = (rcnt > ROUND_LIMIT) ? ROUND_LIMIT : rcnt;
        t = s;
        case (cmd)
            CMD_FWD_ROUNDS: begin
                for (int unsigned r = 0; r < n; r++) begin
                    t = mix_second_half(mix_first_half(t));
                end
            end
            CMD_INV_ROUNDS: begin
                for (int unsigned r = 0; r < n; r++) begin
                    t = unmix_first_half(unmix_second_half(t));
                end
            end
            CMD_FWD_HALF_A: t = mix_first_half(t);
            CMD_FWD_HALF_B: t = mix_second_half(t);
            CMD_INV_HALF_B: t = unmix_second_half(t);
            default: t = s;
        endcase
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offers one job and waits for its transfer. It then records the
    // expected state and may leave a random gap after it.
    task automatic send_job(input logic [CMD_W-1:0] cmd, input logic [RCNT_W-1:0] rcnt,
                            input t_perm_state s, input bit known,
                            input t_perm_state result, input bit back_to_back);
        in_ch.valid       <= 1'b1;
        in_ch.command     <= cmd;
        in_ch.round_count <= rcnt;
        in_ch.word0       <= s[0];
        in_ch.word1       <= s[1];
        in_ch.word2       <= s[2];
        in_ch.word3       <= s[3];
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_states.push_back(known ? result : permute_state(cmd, rcnt, s));
        if (!back_to_back && !calm && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    // Stops offering jobs until every expected state has come out.
    task automatic drain_jobs();
        in_ch.valid <= 1'b0;
        while (pending_states.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_perm_word random_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 32'd1 << $urandom_range(0, 31);
            3:       return ~(32'd1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_job(input bit back_to_back);
        logic [CMD_W-1:0]  cmd;
        logic [RCNT_W-1:0] rcnt;
        t_perm_state       s;
        int unsigned       pick;
        pick = $urandom_range(0, 15);
        cmd  = (pick < 12) ? CMD_W'(pick % 5) : CMD_W'($urandom_range(0, 7));
        case ($urandom_range(0, 9))
            0:       rcnt = RCNT_W'($urandom_range(0, 31));
            1:       rcnt = RCNT_W'(ROUND_LIMIT);
            default: rcnt = RCNT_W'($urandom_range(1, 10));
        endcase
        for (int k = 0; k < 4; k++) begin
            s[k] = random_word();
        end
        send_job(cmd, rcnt, s, 1'b0, ALL_ZERO, back_to_back);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        mismatches   = 0;
        calm         = 1'b0;
        hold_request = 1'b0;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.command     <= CMD_FWD_ROUNDS;
        in_ch.round_count <= '0;
        in_ch.word0       <= '0;
        in_ch.word1       <= '0;
        in_ch.word2       <= '0;
        in_ch.word3       <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed jobs, then an empty pipeline before the random part.
        foreach (directed_jobs[i]) begin
            send_job(directed_jobs[i].cmd, directed_jobs[i].rcnt, directed_jobs[i].state,
                     directed_jobs[i].known, directed_jobs[i].result, 1'b0);
        end
        drain_jobs();

        for (int n = 0; n < RANDOM_JOBS; n++) begin
            // Hold off the output for a long stretch while jobs keep coming.
            if (n == 100) begin
                hold_request = 1'b1;
                for (int k = 0; k < 12; k++) begin
                    send_random_job(1'b1);
                end
            end
            if (n == 300) begin
                drain_jobs();
            end
            // The last part of the run has no idling on either side.
            if (n == RANDOM_JOBS - 100) begin
                calm = 1'b1;
            end
            send_random_job(1'b0);
        end
        drain_jobs();

        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && pending_states.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side: ready pattern with random stalls and one long hold-off
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left != 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES - 1;
                out_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left   = $urandom_range(0, 8);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each output transfer against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_perm_state got;
        t_perm_state want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.out_word3, out_ch.out_word2, out_ch.out_word1, out_ch.out_word0};
            if (pending_states.size() == 0) begin
                $error("unexpected output transfer: %h", got);
                mismatches++;
            end else begin
                want = pending_states.pop_front();
                for (int k = 0; k < 4; k++) begin
                    if (got[k] !== want[k]) begin
                        $error("out_word%0d mismatch: expected %h, actual %h",
                               k, want[k], got[k]);
                        mismatches++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run if no transfer happens for too long
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
